// ===== rtl/u8d_pkg.sv =====
package u8d_pkg;

	localparam int CP_W = 31;

	localparam logic [CP_W-1:0] REPLACEMENT  = 31'h0000_FFFD;
	localparam logic [CP_W-1:0] BYTE_ORDER   = 31'h0000_FEFF;
	localparam logic [CP_W-1:0] SMALL_LIMIT  = 31'h0000_00A0;
	localparam logic [CP_W-1:0] SURR_FIRST   = 31'h0000_D800;
	localparam logic [CP_W-1:0] SURR_TRAIL   = 31'h0000_DC00;
	localparam logic [CP_W-1:0] SURR_LAST    = 31'h0000_DFFF;
	localparam logic [20:0]     SUPP_BASE    = 21'h1_0000;

	localparam logic [1:0] CONT_TAG = 2'b10;

	// one queue entry: a code point, optionally preceded by a replacement
	typedef struct packed {
		logic            pre_repl;
		logic [CP_W-1:0] cp;
	} rec_t;

	typedef struct packed {
		logic valid;
		rec_t rec;
	} push_t;

	typedef struct packed {
		logic valid;
		rec_t rec;
	} head_t;

	typedef struct packed {
		logic phase;
		logic pop;
	} back_stat_t;

endpackage

// ===== rtl/u8d_front.sv =====
module u8d_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,  // text_byte
	input  logic                s_tuser,  // func
	input  logic                full,
	output u8d_pkg::push_t      push
);

	logic [2:0]                 pend_q;
	logic [u8d_pkg::CP_W-1:0]   part_q;
	logic                       held_v_q;
	logic [9:0]                 held_q;

	logic [2:0]                 pend_d;
	logic [u8d_pkg::CP_W-1:0]   part_d;
	logic                       held_v_d;
	logic [9:0]                 held_d;

	logic                       acc;
	logic                       pending;
	logic [u8d_pkg::CP_W-1:0]   acc_val;
	logic [u8d_pkg::CP_W-1:0]   fin_val;
	logic [20:0]                joined;

	assign s_tready = !full;
	assign acc      = s_tvalid && s_tready;
	assign pending  = (pend_q != 3'd0);
	assign acc_val  = {part_q[u8d_pkg::CP_W-7:0], s_tdata[5:0]};
	assign fin_val  = (acc_val < u8d_pkg::SMALL_LIMIT) ? u8d_pkg::REPLACEMENT : acc_val;
	assign joined   = u8d_pkg::SUPP_BASE + {1'b0, held_q, fin_val[9:0]};

	always_comb begin
		pend_d       = pend_q;
		part_d       = part_q;
		held_v_d     = held_v_q;
		held_d       = held_q;
		push.valid   = 1'b0;
		push.rec.pre_repl = 1'b0;
		push.rec.cp  = u8d_pkg::REPLACEMENT;
		if (s_tuser) begin
			// end of text: flush and return to reset state
			push.valid = pending;
			pend_d     = 3'd0;
			part_d     = '0;
			held_v_d   = 1'b0;
			held_d     = '0;
		end else if (!s_tdata[7]) begin
			push.valid        = 1'b1;
			push.rec.pre_repl = pending;
			push.rec.cp       = {{(u8d_pkg::CP_W-8){1'b0}}, s_tdata};
			pend_d            = 3'd0;
		end else if (pending && s_tdata[7:6] == u8d_pkg::CONT_TAG) begin
			part_d = acc_val;
			pend_d = pend_q - 3'd1;
			if (pend_q == 3'd1) begin
				if (fin_val == u8d_pkg::BYTE_ORDER) begin
					push.valid = 1'b0;
				end else if (fin_val >= u8d_pkg::SURR_FIRST
						&& fin_val <= u8d_pkg::SURR_LAST) begin
					if (fin_val < u8d_pkg::SURR_TRAIL) begin
						held_v_d = 1'b1;
						held_d   = fin_val[9:0];
					end else begin
						push.valid  = 1'b1;
						push.rec.cp = held_v_q ?
							{{(u8d_pkg::CP_W-21){1'b0}}, joined} : u8d_pkg::REPLACEMENT;
						held_v_d    = 1'b0;
						held_d      = '0;
					end
				end else begin
					push.valid  = 1'b1;
					push.rec.cp = fin_val;
				end
			end
		end else begin
			// lead byte, stray continuation or 0xFE/0xFF
			if (s_tdata[7:5] == 3'b110) begin
				pend_d = 3'd1;
				part_d = {{(u8d_pkg::CP_W-5){1'b0}}, s_tdata[4:0]};
				push.valid = pending;
			end else if (s_tdata[7:4] == 4'b1110) begin
				pend_d = 3'd2;
				part_d = {{(u8d_pkg::CP_W-4){1'b0}}, s_tdata[3:0]};
				push.valid = pending;
			end else if (s_tdata[7:3] == 5'b11110) begin
				pend_d = 3'd3;
				part_d = {{(u8d_pkg::CP_W-3){1'b0}}, s_tdata[2:0]};
				push.valid = pending;
			end else if (s_tdata[7:2] == 6'b111110) begin
				pend_d = 3'd4;
				part_d = {{(u8d_pkg::CP_W-2){1'b0}}, s_tdata[1:0]};
				push.valid = pending;
			end else if (s_tdata[7:1] == 7'b1111110) begin
				pend_d = 3'd5;
				part_d = {{(u8d_pkg::CP_W-1){1'b0}}, s_tdata[0]};
				push.valid = pending;
			end else begin
				pend_d            = 3'd0;
				push.valid        = 1'b1;
				push.rec.pre_repl = pending;
			end
		end
		if (!acc) begin
			push.valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q   <= 3'd0;
			part_q   <= '0;
			held_v_q <= 1'b0;
			held_q   <= '0;
		end else if (acc) begin
			pend_q   <= pend_d;
			part_q   <= part_d;
			held_v_q <= held_v_d;
			held_q   <= held_d;
		end
	end

endmodule

// ===== rtl/u8d_queue.sv =====
module u8d_queue #(
	parameter int DEPTH = 4  // 2 or more
) (
	input  logic                clk,
	input  logic                arst_n,
	input  u8d_pkg::push_t      push,
	input  logic                pop,
	output logic                full,
	output u8d_pkg::head_t      head
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	u8d_pkg::rec_t    mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	function automatic logic [PTR_W-1:0] nxt(input logic [PTR_W-1:0] p);
		nxt = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign full       = (cnt_q == CNT_W'(DEPTH));
	assign head.valid = (cnt_q != '0);
	assign head.rec   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_q] <= push.rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push.valid) begin
				wr_q <= nxt(wr_q);
			end
			if (pop) begin
				rd_q <= nxt(rd_q);
			end
			if (push.valid && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push.valid) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== rtl/u8d_back.sv =====
module u8d_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  u8d_pkg::head_t            head,
	output u8d_pkg::back_stat_t       stat,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [u8d_pkg::CP_W-1:0]  cp,
	output logic                      m_tlast
);

	logic                     vld_q;
	logic                     last_q;
	logic                     phase_q;
	logic [u8d_pkg::CP_W-1:0] cp_q;
	logic                     load;
	logic                     first_half;

	assign load       = head.valid && (!vld_q || m_tready);
	assign first_half = head.rec.pre_repl && !phase_q;

	assign stat.pop   = load && !first_half;
	assign stat.phase = phase_q;
	assign m_tvalid   = vld_q;
	assign m_tlast    = last_q;
	assign cp         = cp_q;

	always_ff @(posedge clk) begin
		if (load) begin
			cp_q <= first_half ? u8d_pkg::REPLACEMENT : head.rec.cp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= 1'b0;
			last_q  <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			if (load) begin
				vld_q   <= 1'b1;
				last_q  <= !first_half;
				phase_q <= first_half;
			end else if (m_tready) begin
				vld_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/utf8_stream_decoder.sv =====
// channel  | dir | tdata                   | tuser     | tlast
// s_axis   | in  | [7:0] text_byte         | [0] func  | -
// m_axis   | out | [30:0] code_point, pad  | -         | last_of_run
//
// One request per cycle in while the queue has room; one result per cycle out
// while m_tready is high, from a registered output. A request yields zero, one
// or two results; the queue absorbs a two-result request holding the back end.
// s_tready drops only when the QUEUE_DEPTH-entry queue is full.
// Reset returns decoder state, queue and output register to empty.
module utf8_stream_decoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] text_byte
	input  logic        s_tuser,   // [0] func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [30:0] code_point, [31] zero
	output logic        m_tlast
);

	u8d_pkg::push_t           push;
	u8d_pkg::head_t           head;
	u8d_pkg::back_stat_t      bstat;
	logic                     full;
	logic [u8d_pkg::CP_W-1:0] cp;

	u8d_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.full     (full),
		.push     (push)
	);

	u8d_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (bstat.pop),
		.full   (full),
		.head   (head)
	);

	u8d_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.stat     (bstat),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cp       (cp),
		.m_tlast  (m_tlast)
	);

	assign m_tdata = {1'b0, cp};

`ifndef ASSERT_OFF
	a_phase_out : assert property (@(posedge clk) disable iff (!arst_n)
		bstat.phase |-> (m_tvalid && !m_tlast))
		else $error("second-half flag without a first result shown");

	a_pop_head : assert property (@(posedge clk) disable iff (!arst_n)
		bstat.pop |-> head.valid)
		else $error("queue pop while empty");

	a_run_cont : assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
		else $error("run broken after a non-last result");

	a_push_room : assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> !full)
		else $error("queue push while full");
`endif

endmodule

// ===== test/utf8_stream_decoder_test.sv =====
module utf8_stream_decoder_test;

	localparam bit FN_BYTE = 1'b0;
	localparam bit FN_END  = 1'b1;

	localparam int DIR_N      = 28;
	localparam int RAND_ITEMS = 850;
	localparam int CYCLE_CAP  = 600000;
	localparam int TAIL       = 20;

	// one row of the directed table; typed rows carry their own answer
	typedef struct packed {
		bit        fn;
		bit [7:0]  byt;
		bit        typed;
		bit [1:0]  nres;
		bit [30:0] cp0;
		bit [30:0] cp1;
	} req_row_t;

	typedef struct packed {
		bit [30:0] cp;
		bit        last;
	} cp_exp_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        m_tlast;

	// decoder state as seen by the predictor
	bit [2:0]  cont_left;
	bit [30:0] cp_accum;
	bit [15:0] lead_surr;

	cp_exp_t   cp_expected[$];
	bit [8:0]  byte_seq[$];     // {func, byte}
	req_row_t  dir_tab [DIR_N];

	int  errors;
	int  checked;
	int  sent;
	int  cycles;
	bit  src_calm;
	bit  sink_calm;

	utf8_stream_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_CAP) begin
			$display("%0t: timed out", $time);
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic int unsigned draw_wait(input bit calm);
		return calm ? 0 : $urandom_range(0, 15);
	endfunction

	// returns the number of code points one request yields
	function automatic int decode_step(input bit fn, input bit [7:0] b,
			output bit [30:0] cp0, output bit [30:0] cp1);
		bit [30:0] got [2];
		bit [30:0] c;
		int n;
		n = 0;
		got[0] = '0;
		got[1] = '0;
		if (fn == FN_END) begin
			if (cont_left != 3'd0) begin
				got[n] = u8d_pkg::REPLACEMENT;
				n++;
			end
			cont_left = 3'd0;
			cp_accum = '0;
			lead_surr = '0;
		end else if (!b[7]) begin
			if (cont_left != 3'd0) begin
				got[n] = u8d_pkg::REPLACEMENT;
				n++;
			end
			cont_left = 3'd0;
			got[n] = {23'b0, b};
			n++;
		end else if (cont_left != 3'd0 && b[7:6] == u8d_pkg::CONT_TAG) begin
			cp_accum = {cp_accum[24:0], b[5:0]};
			cont_left = cont_left - 3'd1;
			if (cont_left == 3'd0) begin
				c = cp_accum;
				if (c < u8d_pkg::SMALL_LIMIT)
					c = u8d_pkg::REPLACEMENT;
				if (c == u8d_pkg::BYTE_ORDER) begin
					// dropped
				end else if (c >= u8d_pkg::SURR_FIRST && c <= u8d_pkg::SURR_LAST
						&& c < u8d_pkg::SURR_TRAIL) begin
					lead_surr = c[15:0];
				end else begin
					if (c >= u8d_pkg::SURR_TRAIL && c <= u8d_pkg::SURR_LAST) begin
						if ({15'b0, lead_surr} >= u8d_pkg::SURR_FIRST
								&& {15'b0, lead_surr} < u8d_pkg::SURR_TRAIL)
							c = 31'(u8d_pkg::SUPP_BASE)
								+ (({15'b0, lead_surr} - u8d_pkg::SURR_FIRST) << 10)
								+ (c - u8d_pkg::SURR_TRAIL);
						else
							c = u8d_pkg::REPLACEMENT;
						lead_surr = '0;
					end
					got[n] = c;
					n++;
				end
			end
		end else begin
			if (cont_left != 3'd0) begin
				got[n] = u8d_pkg::REPLACEMENT;
				n++;
			end
			casez (b)
				8'b110?????: begin
					cont_left = 3'd1;
					cp_accum = {26'b0, b[4:0]};
				end
				8'b1110????: begin
					cont_left = 3'd2;
					cp_accum = {27'b0, b[3:0]};
				end
				8'b11110???: begin
					cont_left = 3'd3;
					cp_accum = {28'b0, b[2:0]};
				end
				8'b111110??: begin
					cont_left = 3'd4;
					cp_accum = {29'b0, b[1:0]};
				end
				8'b1111110?: begin
					cont_left = 3'd5;
					cp_accum = {30'b0, b[0]};
				end
				default: begin
					got[n] = u8d_pkg::REPLACEMENT;
					n++;
					cont_left = 3'd0;
				end
			endcase
		end
		cp0 = got[0];
		cp1 = got[1];
		return n;
	endfunction

	// UTF-8 encode v over len bytes, overlong forms included
	function automatic void add_char(input bit [30:0] v, input int len);
		bit [7:0] lead;
		if (len == 1) begin
			byte_seq.push_back({FN_BYTE, 1'b0, v[6:0]});
			return;
		end
		lead = ~(8'hFF >> len) | (8'(v >> (6 * (len - 1))) & (8'hFF >> (len + 1)));
		byte_seq.push_back({FN_BYTE, lead});
		for (int k = 1; k < len; k++)
			byte_seq.push_back({FN_BYTE, u8d_pkg::CONT_TAG,
				6'(v >> (6 * (len - 1 - k)))});
	endfunction

	task automatic send_req(input req_row_t row);
		int unsigned gap;
		bit [30:0] r0;
		bit [30:0] r1;
		int n;
		if ($urandom_range(0, 19) == 0)
			src_calm = !src_calm;
		gap = draw_wait(src_calm);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= row.fn;
		s_tdata <= row.byt;
		do @(posedge clk); while (!s_tready);
		// predictor runs on every request so its state stays in step
		n = decode_step(row.fn, row.byt, r0, r1);
		if (row.typed) begin
			n = int'(row.nres);
			r0 = row.cp0;
			r1 = row.cp1;
		end
		if (n > 0)
			cp_expected.push_back('{cp: r0, last: (n == 1)});
		if (n > 1)
			cp_expected.push_back('{cp: r1, last: 1'b1});
		sent++;
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		cp_exp_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (cp_expected.size() == 0) begin
				errors++;
				$display("%0t: code point %h with none expected", $time, m_tdata[30:0]);
			end else begin
				want = cp_expected.pop_front();
				checked++;
				if (m_tdata[30:0] !== want.cp) begin
					errors++;
					$display("%0t: code_point expected %h, got %h", $time, want.cp,
						m_tdata[30:0]);
				end
				if (m_tlast !== want.last) begin
					errors++;
					$display("%0t: last_of_run expected %b, got %b", $time, want.last,
						m_tlast);
				end
				if (m_tdata[31] !== 1'b0) begin
					errors++;
					$display("%0t: pad bit expected 0, got %b", $time, m_tdata[31]);
				end
			end
		end
	end

	// result side back-pressure
	initial begin : sink
		int unsigned stall;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 19) == 0)
				sink_calm = !sink_calm;
			stall = draw_wait(sink_calm);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	initial begin : main
		int rand_sent;
		int kind;
		int len;
		int bits;
		int drain;
		bit [30:0] v;
		bit [30:0] lead;
		bit [30:0] trail;
		errors = 0;
		checked = 0;
		sent = 0;
		src_calm = 1'b0;
		sink_calm = 1'b0;
		cont_left = 3'd0;
		cp_accum = '0;
		lead_surr = '0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = FN_BYTE;

		// fn, byte, typed, results, first, second
		dir_tab = '{
			'{FN_BYTE, 8'h00, 1'b1, 2'd1, 31'h0,                 31'h0},
			'{FN_BYTE, 8'h7F, 1'b1, 2'd1, 31'h7F,                31'h0},
			'{FN_BYTE, 8'h80, 1'b1, 2'd1, u8d_pkg::REPLACEMENT,  31'h0},
			'{FN_BYTE, 8'hFF, 1'b1, 2'd1, u8d_pkg::REPLACEMENT,  31'h0},
			// overlong 'A' falls below the small limit
			'{FN_BYTE, 8'hC1, 1'b1, 2'd0, 31'h0,                 31'h0},
			'{FN_BYTE, 8'h81, 1'b1, 2'd1, u8d_pkg::REPLACEMENT,  31'h0},
			// byte-order mark
			'{FN_BYTE, 8'hEF, 1'b0, 2'd0, 31'h0,                 31'h0},
			'{FN_BYTE, 8'hBB, 1'b0, 2'd0, 31'h0,                 31'h0},
			'{FN_BYTE, 8'hBF, 1'b0, 2'd0, 31'h0,                 31'h0},
			// lead then trailing surrogate, then a lone trailing one
			'{FN_BYTE, 8'hED, 1'b0, 2'd0, 31'h0,                 31'h0},
			'{FN_BYTE, 8'hA0, 1'b0, 2'd0, 31'h0,                 31'h0},
			'{FN_BYTE, 8'h80, 1'b0, 2'd0, 31'h0,                 31'h0},
			'{FN_BYTE, 8'hED, 1'b0, 2'd0, 31'h0,                 31'h0},
			'{FN_BYTE, 8'hB0, 1'b0, 2'd0, 31'h0,                 31'h0},
			'{FN_BYTE, 8'h80, 1'b0, 2'd0, 31'h0,                 31'h0},
			'{FN_BYTE, 8'hED, 1'b0, 2'd0, 31'h0,                 31'h0},
			'{FN_BYTE, 8'hB0, 1'b0, 2'd0, 31'h0,                 31'h0},
			'{FN_BYTE, 8'h80, 1'b0, 2'd0, 31'h0,                 31'h0},
			// cut short by a new lead, then the six-byte maximum
			'{FN_BYTE, 8'hF4, 1'b1, 2'd0, 31'h0,                 31'h0},
			'{FN_BYTE, 8'hFD, 1'b1, 2'd1, u8d_pkg::REPLACEMENT,  31'h0},
			'{FN_BYTE, 8'hBF, 1'b1, 2'd0, 31'h0,                 31'h0},
			'{FN_BYTE, 8'hBF, 1'b1, 2'd0, 31'h0,                 31'h0},
			'{FN_BYTE, 8'hBF, 1'b1, 2'd0, 31'h0,                 31'h0},
			'{FN_BYTE, 8'hBF, 1'b1, 2'd0, 31'h0,                 31'h0},
			'{FN_BYTE, 8'hBF, 1'b1, 2'd1, 31'h7FFF_FFFF,         31'h0},
			// end of text flushes, then finds nothing pending
			'{FN_BYTE, 8'hE0, 1'b1, 2'd0, 31'h0,                 31'h0},
			'{FN_END,  8'hFF, 1'b1, 2'd1, u8d_pkg::REPLACEMENT,  31'h0},
			'{FN_END,  8'h00, 1'b1, 2'd0, 31'h0,                 31'h0}
		};

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_tab[i])
			send_req(dir_tab[i]);

		rand_sent = 0;
		while (rand_sent < RAND_ITEMS) begin
			byte_seq.delete();
			kind = $urandom_range(0, 99);
			if (kind < 45) begin
				len = $urandom_range(1, 6);
				bits = (len == 1) ? 7 : (7 - len) + 6 * (len - 1);
				v = 31'($urandom) & 31'((33'h1 << bits) - 1);
				add_char(v, len);
			end else if (kind < 60) begin
				lead = u8d_pkg::SURR_FIRST + 31'($urandom_range(0, 1023));
				trail = u8d_pkg::SURR_TRAIL + 31'($urandom_range(0, 1023));
				if ($urandom_range(0, 3) != 0)
					add_char(lead, 3);
				if ($urandom_range(0, 3) == 0)
					add_char(31'($urandom_range(0, 127)), 1);
				if ($urandom_range(0, 3) != 0)
					add_char(trail, 3);
			end else if (kind < 65) begin
				add_char(u8d_pkg::BYTE_ORDER, 3);
			end else if (kind < 77) begin
				// truncated sequence; what follows interrupts it unless it is a continuation byte
				len = $urandom_range(2, 6);
				add_char(31'($urandom), len);
				repeat ($urandom_range(1, len - 1))
					void'(byte_seq.pop_back());
			end else if (kind < 83) begin
				byte_seq.push_back({FN_END, 8'($urandom)});
			end else begin
				byte_seq.push_back({FN_BYTE, 8'($urandom)});
			end
			foreach (byte_seq[i]) begin
				send_req('{byte_seq[i][8], byte_seq[i][7:0], 1'b0, 2'd0, 31'h0, 31'h0});
				rand_sent++;
			end
		end
		s_tvalid <= 1'b0;

		drain = 0;
		while (cp_expected.size() != 0 && drain < 5000) begin
			@(posedge clk);
			drain++;
		end
		repeat (TAIL) @(posedge clk);
		if (cp_expected.size() != 0) begin
			errors++;
			$display("%0t: %0d expected code points never arrived", $time,
				cp_expected.size());
		end

		$display("%0d requests sent (%0d from the table), %0d code points compared.",
			sent, DIR_N, checked);
		$display("Mix: ASCII, 2..6 byte forms, surrogates, BOMs, truncated and stray bytes.");
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/u8d_pkg.sv
rtl/u8d_front.sv
rtl/u8d_queue.sv
rtl/u8d_back.sv
rtl/utf8_stream_decoder.sv
test/utf8_stream_decoder_test.sv
